[rtl/fcw_pkg.sv]
// fcw_pkg: shared types and constants for the FAT12 chain walker.
// No dependencies; imported by every rtl module of the block.
package fcw_pkg;

    localparam int CLUSTER_W = 12;
    localparam int BYTE_W    = 8;

    localparam logic [CLUSTER_W-1:0] BAD_MARK = 12'hFF7;
    localparam logic [CLUSTER_W-1:0] END_MARK = 12'hFFF;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_WALK = 1'b1;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_THIRD
    } t_byte_phase;

    typedef enum logic [1:0] {
        WS_IDLE,
        WS_READ,
        WS_EVAL
    } t_walk_state;

    // one table write request
    typedef struct packed {
        logic                 en;
        logic [CLUSTER_W-1:0] addr;
        logic [CLUSTER_W-1:0] data;
    } t_tbl_wr;

endpackage

[rtl/fcw_table_ram.sv]
// fcw_table_ram: allocation table storage, one write port, one registered read port.
// Depends on fcw_pkg (t_tbl_wr, CLUSTER_W).
module fcw_table_ram #(
    parameter int DEPTH = 4096
) (
    input  logic                                 i_clk,
    input  fcw_pkg::t_tbl_wr                     i_wr,
    input  logic                                 i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]             i_rd_addr,
    output logic [fcw_pkg::CLUSTER_W-1:0]        o_rd_data
);
    import fcw_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [CLUSTER_W-1:0] r_mem [DEPTH];
    logic [CLUSTER_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/fcw_byte_packer.sv]
// fcw_byte_packer: gathers raw table bytes, unpacks each triple into two
// 12-bit entries and writes them at the rising pointer. Depends on fcw_pkg.
module fcw_byte_packer #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [fcw_pkg::BYTE_W-1:0]    i_byte,
    output fcw_pkg::t_tbl_wr              o_wr,
    output logic                          o_idle
);
    import fcw_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_ENTRIES - 1);

    t_byte_phase          r_phase, n_phase;
    logic [BYTE_W-1:0]    r_held_first, n_held_first;
    logic [BYTE_W-1:0]    r_held_second, n_held_second;
    logic [AW-1:0]        r_wp, n_wp;
    logic                 r_busy, n_busy;
    logic [CLUSTER_W-1:0] r_e1, n_e1;
    logic [AW-1:0]        wp_next;

    assign wp_next = (r_wp == LAST_SLOT) ? '0 : r_wp + AW'(1);

    always_comb begin
        n_phase       = r_phase;
        n_held_first  = r_held_first;
        n_held_second = r_held_second;
        n_wp          = r_wp;
        n_busy        = r_busy;
        n_e1          = r_e1;
        o_wr.en       = 1'b0;
        o_wr.addr     = CLUSTER_W'(r_wp);
        o_wr.data     = r_e1;
        if (r_busy) begin
            // second entry of the triple
            o_wr.en = 1'b1;
            n_wp    = wp_next;
            n_busy  = 1'b0;
        end else if (i_load) begin
            case (r_phase)
                PH_FIRST: begin
                    n_held_first = i_byte;
                    n_phase      = PH_SECOND;
                end
                PH_SECOND: begin
                    n_held_second = i_byte;
                    n_phase       = PH_THIRD;
                end
                PH_THIRD: begin
                    o_wr.en   = 1'b1;
                    o_wr.data = {r_held_second[3:0], r_held_first};
                    n_e1      = {i_byte, r_held_second[7:4]};
                    n_wp      = wp_next;
                    n_busy    = 1'b1;
                    n_phase   = PH_FIRST;
                end
                default: begin
                    n_held_first = i_byte;
                    n_phase      = PH_SECOND;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_FIRST;
            r_held_first  <= '0;
            r_held_second <= '0;
            r_wp          <= '0;
            r_busy        <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_held_first  <= n_held_first;
            r_held_second <= n_held_second;
            r_wp          <= n_wp;
            r_busy        <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e1 <= n_e1;
    end

    assign o_idle = !r_busy;

endmodule

[rtl/fcw_walker.sv]
// fcw_walker: chain walk sequencer; reads at most one table entry per cluster and
// drives the registered result stage. Depends on fcw_pkg.
module fcw_walker #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int MAX_RUN       = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [fcw_pkg::CLUSTER_W-1:0]      i_start_cluster,
    output logic                               o_rd_en,
    output logic [$clog2(TABLE_ENTRIES)-1:0]   o_rd_addr,
    input  logic [fcw_pkg::CLUSTER_W-1:0]      i_rd_data,
    output logic                               o_idle,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [fcw_pkg::CLUSTER_W-1:0]      o_cluster,
    output logic                               o_last,
    output logic                               o_bad,
    output logic                               o_truncated
);
    import fcw_pkg::*;

    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(MAX_RUN + 1);

    t_walk_state          r_state, n_state;
    logic [CLUSTER_W-1:0] r_cur;
    logic [CNT_W-1:0]     r_count;
    logic                 r_oor;
    logic                 r_o_valid;
    logic [CLUSTER_W-1:0] r_o_cluster;
    logic                 r_o_last, r_o_bad, r_o_trunc;

    logic                 cur_oor;
    logic [CLUSTER_W-1:0] entry;
    logic                 ev_bad, ev_end, ev_trunc, ev_last;
    logic                 out_free;
    logic                 ld_out;

    assign cur_oor  = {1'b0, r_cur} >= (CLUSTER_W+1)'(TABLE_ENTRIES);
    assign entry    = r_oor ? END_MARK : i_rd_data;
    assign ev_bad   = entry == BAD_MARK;
    assign ev_end   = entry > BAD_MARK;
    assign ev_trunc = !ev_bad && !ev_end && (r_count >= CNT_W'(MAX_RUN));
    assign ev_last  = ev_bad || ev_end || ev_trunc;
    assign out_free = !r_o_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            WS_IDLE: begin
                if (i_start) begin
                    n_state = WS_READ;
                end
            end
            WS_READ: n_state = WS_EVAL;
            WS_EVAL: begin
                if (out_free) begin
                    n_state = ev_last ? WS_IDLE : WS_READ;
                end
            end
            default: n_state = WS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_rd_en = 1'b0;
        ld_out  = 1'b0;
        o_idle  = 1'b0;
        case (r_state)
            WS_IDLE: o_idle  = 1'b1;
            WS_READ: o_rd_en = !cur_oor;
            WS_EVAL: ld_out  = out_free;
            default: o_idle  = 1'b0;
        endcase
    end

    assign o_rd_addr = r_cur[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= WS_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ld_out) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == WS_IDLE && i_start) begin
            r_cur   <= i_start_cluster;
            r_count <= CNT_W'(1);
        end else if (ld_out && !ev_last) begin
            r_cur   <= entry;
            r_count <= r_count + CNT_W'(1);
        end
        if (r_state == WS_READ) begin
            r_oor <= cur_oor;
        end
        if (ld_out) begin
            r_o_cluster <= r_cur;
            r_o_last    <= ev_last;
            r_o_bad     <= ev_bad;
            r_o_trunc   <= ev_trunc;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_cluster   = r_o_cluster;
    assign o_last      = r_o_last;
    assign o_bad       = r_o_bad;
    assign o_truncated = r_o_trunc;

endmodule

[rtl/fat12_chain_walker_top.sv]
// fat12_chain_walker_top: FAT12 allocation table with chain walk.
// Depends on fcw_pkg, fcw_table_ram, fcw_byte_packer, fcw_walker.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+----------------------------------------------
//  in      | i_in_valid  | o_in_ready  | i_op, i_fat_byte, i_start_cluster
//  out     | o_out_valid | i_out_ready | o_cluster, o_last, o_bad, o_truncated
//
// The third byte of a triple holds off the next input beat, since both
// unpacked entries go through the single table write port.
// A walk handles each result cluster with a table read step, then an evaluate step
// into the result register, and waits there on any output stall.
// Reset clears the byte phase, held bytes, write pointer and control state;
// the table itself is not cleared and holds nothing valid until loaded.
// The result register lets a finished last beat wait while the next input beat
// is taken; a stalled result holds the walk in its evaluate step.
module fat12_chain_walker_top #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int MAX_RUN       = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_op,
    input  logic [fcw_pkg::BYTE_W-1:0]        i_fat_byte,
    input  logic [fcw_pkg::CLUSTER_W-1:0]     i_start_cluster,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [fcw_pkg::CLUSTER_W-1:0]     o_cluster,
    output logic                              o_last,
    output logic                              o_bad,
    output logic                              o_truncated
);
    import fcw_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);

    t_tbl_wr              tbl_wr;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [CLUSTER_W-1:0] rd_data;
    logic                 packer_idle;
    logic                 walker_idle;
    logic                 in_beat;
    logic                 load_beat;
    logic                 walk_beat;

    // Inputs wait while either side is busy: this also keeps a walk from
    // reading an entry whose second write is still pending.
    assign o_in_ready = packer_idle && walker_idle;
    assign in_beat    = i_in_valid && o_in_ready;
    assign load_beat  = in_beat && (i_op == OP_LOAD);
    assign walk_beat  = in_beat && (i_op == OP_WALK);

    fcw_table_ram #(
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    fcw_byte_packer #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load_beat),
        .i_byte  (i_fat_byte),
        .o_wr    (tbl_wr),
        .o_idle  (packer_idle)
    );

    fcw_walker #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_RUN       (MAX_RUN)
    ) u_walker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (walk_beat),
        .i_start_cluster (i_start_cluster),
        .o_rd_en         (rd_en),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data),
        .o_idle          (walker_idle),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_cluster       (o_cluster),
        .o_last          (o_last),
        .o_bad           (o_bad),
        .o_truncated     (o_truncated)
    );

endmodule

[rtl/fcw_checker.sv]
// fcw_checker: port-level assertions for fat12_chain_walker_top, with bind.
// Depends on fcw_pkg (OP_WALK, widths).
module fcw_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          i_op,
    input logic [fcw_pkg::BYTE_W-1:0]    i_fat_byte,
    input logic [fcw_pkg::CLUSTER_W-1:0] i_start_cluster,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [fcw_pkg::CLUSTER_W-1:0] o_cluster,
    input logic                          o_last,
    input logic                          o_bad,
    input logic                          o_truncated
);
    import fcw_pkg::*;

    // no result may be pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // bad and truncated only on the closing beat, never both
    a_flags_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_bad || o_truncated) |-> o_last && !(o_bad && o_truncated))
        else $error("walk status flag on a non-final beat");

    // a walk beat takes the block busy for at least its first table read
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op == OP_WALK) |=> !o_in_ready)
        else $error("input accepted during walk start");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cluster)
            && $stable(o_last) && $stable(o_bad) && $stable(o_truncated))
        else $error("stalled result changed");

endmodule

bind fat12_chain_walker_top fcw_checker u_fcw_checker (.*);
